### hw/rtl/keypad_code_lock_controller_core_macros.svh
// Assertion helpers for the keypad code lock checker.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_CORE_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KCLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define KCLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/kclc_pkg.sv
`timescale 1ns / 1ps

package kclc_pkg;

  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CODE_W      = 32;
  localparam int FAIL_W      = 4;
  localparam int TICKS_W     = 6;
  localparam int TICK_CNT_W  = 8;
  localparam int PHASE_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SHOWN_CHARS  = 4;
  localparam int MASTER_CHARS = 4;

  localparam logic [CHAR_W-1:0] NO_KEY      = 8'h10;
  localparam logic [CHAR_W-1:0] CONFIRM_KEY = 8'h23;
  localparam logic [CHAR_W-1:0] BLANK       = 8'h2D;

  localparam logic [CODE_W-1:0]  MASTER_CODE_RST   = 32'h3132_3334;
  localparam logic [FAIL_W-1:0]  MAX_FAILURES_RST  = 4'd3;
  localparam logic [TICKS_W-1:0] MESSAGE_TICKS_RST = 6'd20;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_MASTER = 2'd2
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN   = 2'd0,
    MODE_CLOSED = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_CORRECT = 2'd1,
    VERDICT_WRONG   = 2'd2,
    VERDICT_LOCKOUT = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    MOTOR_NONE  = 2'd0,
    MOTOR_CLOSE = 2'd1,
    MOTOR_OPEN  = 2'd2
  } motor_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MASTER_CODE   = 2'd0,
    REG_MAX_FAILURES  = 2'd1,
    REG_MESSAGE_TICKS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CODE_W-1:0]  master_code;
    logic [FAIL_W-1:0]  max_failures;
    logic [TICKS_W-1:0] message_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t                lock_mode;
    verdict_t             verdict;
    motor_t               motor_cmd;
    logic                 leds_on;
    logic [PHASE_W-1:0]   message_phase;
    logic [CODE_W-1:0]    shown_code;
    logic                 master_pending;
  } result_t;

endpackage

### hw/rtl/kclc_if.sv
`timescale 1ns / 1ps

interface kclc_in_if;
  logic                          valid;
  logic                          ready;
  logic [kclc_pkg::CMD_W-1:0]    cmd;
  logic [kclc_pkg::CHAR_W-1:0]   key_code;

  modport source (output valid, cmd, key_code, input ready);
  modport sink   (input valid, cmd, key_code, output ready);
endinterface

interface kclc_out_if;
  logic                          valid;
  logic                          ready;
  logic [kclc_pkg::MODE_W-1:0]   lock_mode;
  logic [1:0]                    verdict;
  logic [1:0]                    motor_cmd;
  logic                          leds_on;
  logic [kclc_pkg::PHASE_W-1:0]  message_phase;
  logic [kclc_pkg::CODE_W-1:0]   shown_code;
  logic                          master_pending;

  modport source (output valid, lock_mode, verdict, motor_cmd, leds_on, message_phase,
                  shown_code, master_pending, input ready);
  modport sink   (input valid, lock_mode, verdict, motor_cmd, leds_on, message_phase,
                  shown_code, master_pending, output ready);
endinterface

### hw/rtl/keypad_code_lock_controller_core.sv
`timescale 1ns / 1ps

// Keypad code lock: one beat in on item (tick, key or master button) gives
// exactly one result beat on result, showing the lock state after that event.
// An item is registered, runs through the combinational step logic and lands
// in the result register; a new item can be taken every cycle, and the
// result register decouples the two sides: only a full result register held
// by a low result.ready stalls the input.
// Configuration writes land at the next clock edge and should be issued only
// while no item is in flight.
module keypad_code_lock_controller_core #(
  parameter int CODE_LEN = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kclc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kclc_pkg::CFG_DATA_W-1:0]    cfg_data,
  kclc_in_if.sink                            item,
  kclc_out_if.source                         result
);

  kclc_pkg::cfg_t                  cfg;
  kclc_pkg::result_t               res_next;
  logic                            pend_valid;
  logic [kclc_pkg::CMD_W-1:0]      pend_cmd;
  logic [kclc_pkg::CHAR_W-1:0]     pend_key;
  logic                            space;
  logic                            fire;

  assign fire = pend_valid && space;

  kclc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kclc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .advance  (space),
    .valid    (pend_valid),
    .cmd      (pend_cmd),
    .key_code (pend_key)
  );

  kclc_step #(
    .CODE_LEN (CODE_LEN)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cmd      (pend_cmd),
    .key_code (pend_key),
    .cfg      (cfg),
    .res_next (res_next)
  );

  kclc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .res_next (res_next),
    .space    (space),
    .result   (result)
  );

endmodule

### hw/rtl/kclc_cfg.sv
`timescale 1ns / 1ps

module kclc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kclc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kclc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output kclc_pkg::cfg_t                     cfg
);

  kclc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.master_code   <= kclc_pkg::MASTER_CODE_RST;
      regs.max_failures  <= kclc_pkg::MAX_FAILURES_RST;
      regs.message_ticks <= kclc_pkg::MESSAGE_TICKS_RST;
    end else if (cfg_we) begin
      case (kclc_pkg::reg_index_t'(cfg_index))
        kclc_pkg::REG_MASTER_CODE:
          regs.master_code <= cfg_data[kclc_pkg::CODE_W-1:0];
        kclc_pkg::REG_MAX_FAILURES:
          regs.max_failures <= cfg_data[kclc_pkg::FAIL_W-1:0];
        kclc_pkg::REG_MESSAGE_TICKS:
          regs.message_ticks <= cfg_data[kclc_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hw/rtl/kclc_in_stage.sv
`timescale 1ns / 1ps

module kclc_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  kclc_in_if.sink                       item,
  input  logic                          advance,
  output logic                          valid,
  output logic [kclc_pkg::CMD_W-1:0]    cmd,
  output logic [kclc_pkg::CHAR_W-1:0]   key_code
);

  logic accept;
  logic valid_next;

  assign item.ready = !valid || advance;
  assign accept     = item.valid && item.ready;

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= item.cmd;
      key_code <= item.key_code;
    end
  end

endmodule

### hw/rtl/kclc_step.sv
`timescale 1ns / 1ps

module kclc_step #(
  parameter int CODE_LEN = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [kclc_pkg::CMD_W-1:0]    cmd,
  input  logic [kclc_pkg::CHAR_W-1:0]   key_code,
  input  kclc_pkg::cfg_t                cfg,
  output kclc_pkg::result_t             res_next
);

  localparam int CNT_W = $clog2(CODE_LEN + 1);
  localparam int CW    = kclc_pkg::CHAR_W;
  localparam int TW    = kclc_pkg::TICK_CNT_W;

  kclc_pkg::mode_t                 mode, mode_next;
  logic [CW-1:0]                   stored_code [CODE_LEN];
  logic [CW-1:0]                   stored_code_next [CODE_LEN];
  logic [CW-1:0]                   entry_buffer [CODE_LEN];
  logic [CW-1:0]                   entry_buffer_next [CODE_LEN];
  logic [CW-1:0]                   entry_new [CODE_LEN];
  logic [CW-1:0]                   master_ref [CODE_LEN];
  logic [CW-1:0]                   shown_src [CODE_LEN];
  logic [CNT_W-1:0]                stored_count, stored_count_next;
  logic [CNT_W-1:0]                entry_count, entry_count_next;
  logic [kclc_pkg::FAIL_W-1:0]     failure_count, failure_count_next;
  logic [kclc_pkg::FAIL_W-1:0]     fail_inc, fail_lim;
  logic [TW-1:0]                   tick_count, tick_count_next;
  logic                            master_armed, master_armed_next;

  logic [TW-1:0]                   mt;
  logic [TW:0]                     mt2, mt3, period, tick_inc;
  logic                            use_master, entry_full, match;
  logic [CW-1:0]                   ref_char;

  for (genvar g = 0; g < CODE_LEN; g++) begin : g_master
    if (g < kclc_pkg::MASTER_CHARS) begin : g_char
      assign master_ref[g] =
        cfg.master_code[kclc_pkg::CODE_W-1-CW*g -: CW];
    end else begin : g_blank
      assign master_ref[g] = kclc_pkg::BLANK;
    end
  end

  always_comb begin
    mt = (cfg.message_ticks == '0) ? TW'(1) : TW'(cfg.message_ticks);
    mt2 = {mt, 1'b0};
    mt3 = mt2 + {1'b0, mt};
    fail_lim = (cfg.max_failures == '0) ? kclc_pkg::FAIL_W'(1) : cfg.max_failures;
    fail_inc = failure_count + kclc_pkg::FAIL_W'(1);
    use_master = (mode == kclc_pkg::MODE_LOCKED);
    entry_full = (entry_count >= CNT_W'(CODE_LEN - 1));

    for (int i = 0; i < CODE_LEN; i++) begin
      entry_new[i] = (entry_count == CNT_W'(i)) ? key_code : entry_buffer[i];
    end
    match = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      ref_char = use_master ? master_ref[i] : stored_code[i];
      if (ref_char != entry_new[i]) begin
        match = 1'b0;
      end
    end

    period   = use_master ? mt2 : mt3;
    tick_inc = {1'b0, tick_count} + (TW + 1)'(1);

    mode_next          = mode;
    stored_code_next   = stored_code;
    entry_buffer_next  = entry_buffer;
    stored_count_next  = stored_count;
    entry_count_next   = entry_count;
    failure_count_next = failure_count;
    tick_count_next    = tick_count;
    master_armed_next  = master_armed;
    res_next.verdict   = kclc_pkg::VERDICT_NONE;
    res_next.motor_cmd = kclc_pkg::MOTOR_NONE;

    case (kclc_pkg::cmd_t'(cmd))
      kclc_pkg::CMD_TICK: begin
        tick_count_next = (tick_inc >= period) ? '0 : tick_inc[TW-1:0];
      end
      kclc_pkg::CMD_MASTER: begin
        master_armed_next = 1'b1;
      end
      kclc_pkg::CMD_KEY: begin
        if (key_code != kclc_pkg::NO_KEY) begin
          if (mode == kclc_pkg::MODE_OPEN) begin
            if (stored_count < CNT_W'(CODE_LEN)) begin
              for (int i = 0; i < CODE_LEN; i++) begin
                if (stored_count == CNT_W'(i)) begin
                  stored_code_next[i] = key_code;
                end
              end
              stored_count_next = stored_count + CNT_W'(1);
            end else if (key_code == kclc_pkg::CONFIRM_KEY) begin
              stored_count_next  = '0;
              tick_count_next    = '0;
              mode_next          = kclc_pkg::MODE_CLOSED;
              res_next.motor_cmd = kclc_pkg::MOTOR_CLOSE;
            end
          end else if (mode == kclc_pkg::MODE_CLOSED || master_armed) begin
            if (entry_full) begin
              entry_count_next = '0;
              for (int i = 0; i < CODE_LEN; i++) begin
                entry_buffer_next[i] = kclc_pkg::BLANK;
              end
              if (match) begin
                res_next.verdict   = kclc_pkg::VERDICT_CORRECT;
                res_next.motor_cmd = kclc_pkg::MOTOR_OPEN;
                failure_count_next = '0;
                if (use_master) begin
                  master_armed_next = 1'b0;
                end
                mode_next         = kclc_pkg::MODE_OPEN;
                stored_count_next = '0;
                tick_count_next   = '0;
                for (int i = 0; i < CODE_LEN; i++) begin
                  stored_code_next[i] = kclc_pkg::BLANK;
                end
              end else if (use_master) begin
                res_next.verdict = kclc_pkg::VERDICT_WRONG;
              end else if (fail_inc >= fail_lim || fail_inc == '0) begin
                failure_count_next = '0;
                tick_count_next    = '0;
                mode_next          = kclc_pkg::MODE_LOCKED;
                res_next.verdict   = kclc_pkg::VERDICT_LOCKOUT;
              end else begin
                failure_count_next = fail_inc;
                res_next.verdict   = kclc_pkg::VERDICT_WRONG;
              end
            end else begin
              entry_buffer_next = entry_new;
              entry_count_next  = entry_count + CNT_W'(1);
            end
          end
        end
      end
      default: ;
    endcase

    // phase = tick / mt capped at 2, done with two compares; in lockout phase is 0 and leds_on = tick < mt
    res_next.leds_on       = 1'b0;
    res_next.message_phase = '0;
    if (mode_next == kclc_pkg::MODE_LOCKED) begin
      res_next.leds_on = (tick_count_next < mt);
    end else if ({1'b0, tick_count_next} >= mt2) begin
      res_next.message_phase = kclc_pkg::PHASE_W'(2);
    end else if (tick_count_next >= mt) begin
      res_next.message_phase = kclc_pkg::PHASE_W'(1);
    end

    for (int i = 0; i < CODE_LEN; i++) begin
      shown_src[i] = (mode_next == kclc_pkg::MODE_OPEN) ? stored_code_next[i]
                                                        : entry_buffer_next[i];
    end
    for (int i = 0; i < kclc_pkg::SHOWN_CHARS; i++) begin
      res_next.shown_code[kclc_pkg::CODE_W-1-CW*i -: CW] =
        (i < CODE_LEN) ? shown_src[i % CODE_LEN] : kclc_pkg::BLANK;
    end

    res_next.lock_mode      = mode_next;
    res_next.master_pending = master_armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= kclc_pkg::MODE_OPEN;
      stored_count  <= '0;
      entry_count   <= '0;
      failure_count <= '0;
      tick_count    <= '0;
      master_armed  <= 1'b0;
      for (int i = 0; i < CODE_LEN; i++) begin
        stored_code[i]  <= kclc_pkg::BLANK;
        entry_buffer[i] <= kclc_pkg::BLANK;
      end
    end else if (fire) begin
      mode          <= mode_next;
      stored_count  <= stored_count_next;
      entry_count   <= entry_count_next;
      failure_count <= failure_count_next;
      tick_count    <= tick_count_next;
      master_armed  <= master_armed_next;
      stored_code   <= stored_code_next;
      entry_buffer  <= entry_buffer_next;
    end
  end

endmodule

### hw/rtl/kclc_out_stage.sv
`timescale 1ns / 1ps

module kclc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  kclc_pkg::result_t    res_next,
  output logic                 space,
  kclc_out_if.source           result
);

  logic               valid, valid_next;
  kclc_pkg::result_t  res;

  assign space = !valid || result.ready;

  always_comb begin
    valid_next = valid;
    if (fire) begin
      valid_next = 1'b1;
    end else if (result.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign result.valid          = valid;
  assign result.lock_mode      = res.lock_mode;
  assign result.verdict        = res.verdict;
  assign result.motor_cmd      = res.motor_cmd;
  assign result.leds_on        = res.leds_on;
  assign result.message_phase  = res.message_phase;
  assign result.shown_code     = res.shown_code;
  assign result.master_pending = res.master_pending;

endmodule

### hw/rtl/kclc_checker.sv
`timescale 1ns / 1ps
`include "keypad_code_lock_controller_core_macros.svh"

module kclc_assert (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  input  logic                           ready,
  input  logic [kclc_pkg::MODE_W-1:0]    lock_mode,
  input  logic [1:0]                     verdict,
  input  logic [1:0]                     motor_cmd,
  input  logic                           leds_on,
  input  logic [kclc_pkg::PHASE_W-1:0]   message_phase,
  input  logic [kclc_pkg::CODE_W-1:0]    shown_code
);

  `KCLC_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(shown_code) && $stable(lock_mode), "stalled result beat changed")

  `KCLC_ASSERT_NOW(a_leds_locked, valid && leds_on, lock_mode == kclc_pkg::MODE_LOCKED, "LEDs on outside lockout")

  `KCLC_ASSERT_NOW(a_phase_range, valid && message_phase != 2'd0, lock_mode != kclc_pkg::MODE_LOCKED && message_phase != 2'd3, "bad message phase")

  `KCLC_ASSERT_NOW(a_open_motor, valid && verdict == kclc_pkg::VERDICT_CORRECT, lock_mode == kclc_pkg::MODE_OPEN && motor_cmd == kclc_pkg::MOTOR_OPEN, "correct code without opening")

  `KCLC_ASSERT_NOW(a_close_motor, valid && motor_cmd == kclc_pkg::MOTOR_CLOSE, lock_mode == kclc_pkg::MODE_CLOSED && verdict == kclc_pkg::VERDICT_NONE, "close command outside closing")

endmodule

bind keypad_code_lock_controller_core kclc_assert u_chk (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .lock_mode     (result.lock_mode),
  .verdict       (result.verdict),
  .motor_cmd     (result.motor_cmd),
  .leds_on       (result.leds_on),
  .message_phase (result.message_phase),
  .shown_code    (result.shown_code)
);
